// ===== hdl/tfoc_pkg.sv =====
// Shared types, codes and microcode table for the tiny four-opcode processor.
`default_nettype none

package tfoc_pkg;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 112;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_STEP  = 2'd1;
   localparam logic [1:0] CMD_RREG  = 2'd2;
   localparam logic [1:0] CMD_RMEM  = 2'd3;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_HALT    = 2'd1;
   localparam logic [1:0] ST_UNKNOWN = 2'd2;
   localparam logic [1:0] ST_FAULT   = 2'd3;

   localparam logic [1:0] DK_NONE = 2'd0;
   localparam logic [1:0] DK_REG  = 2'd1;
   localparam logic [1:0] DK_MEM  = 2'd2;

   localparam logic [31:0] OPC_LOAD  = 32'd1;
   localparam logic [31:0] OPC_ADD   = 32'd2;
   localparam logic [31:0] OPC_STORE = 32'd3;

   // capture target for the registered memory read data
   localparam logic [2:0] CAP_NONE = 3'd0;
   localparam logic [2:0] CAP_OPC  = 3'd1;
   localparam logic [2:0] CAP_OP0  = 3'd2;
   localparam logic [2:0] CAP_OP1  = 3'd3;
   localparam logic [2:0] CAP_OP2  = 3'd4;

   localparam logic [3:0] ACT_NONE  = 4'd0;
   localparam logic [3:0] ACT_WRITE = 4'd1;
   localparam logic [3:0] ACT_RREG  = 4'd2;
   localparam logic [3:0] ACT_RMEM  = 4'd3;
   localparam logic [3:0] ACT_UNK   = 4'd4;
   localparam logic [3:0] ACT_PAST  = 4'd5;
   localparam logic [3:0] ACT_HALT  = 4'd6;
   localparam logic [3:0] ACT_LS    = 4'd7;
   localparam logic [3:0] ACT_ACC   = 4'd8;
   localparam logic [3:0] ACT_ADD   = 4'd9;

   localparam logic [1:0] J_NEXT  = 2'd0;
   localparam logic [1:0] J_PCEND = 2'd1;
   localparam logic [1:0] J_ZERO  = 2'd2;
   localparam logic [1:0] J_OPC   = 2'd3;

   localparam logic [1:0] KIND_LS  = 2'd0;
   localparam logic [1:0] KIND_ADD = 2'd1;
   localparam logic [1:0] KIND_UNK = 2'd2;

   localparam logic [4:0] ROW_WRITE = 5'd0;
   localparam logic [4:0] ROW_RREG  = 5'd1;
   localparam logic [4:0] ROW_RMEM  = 5'd2;
   localparam logic [4:0] ROW_STEP  = 5'd4;
   localparam logic [4:0] ROW_LS    = 5'd7;
   localparam logic [4:0] ROW_ADD   = 5'd11;
   localparam logic [4:0] ROW_UNK   = 5'd16;
   localparam logic [4:0] ROW_PAST  = 5'd17;
   localparam logic [4:0] ROW_HALT  = 5'd18;

   typedef struct packed {
      logic       rd_pc;
      logic       pc_inc;
      logic [2:0] cap;
      logic [3:0] act;
      logic       fin;
      logic [1:0] jmp;
   } ctl_type;

   typedef struct packed {
      logic       pc_end;
      logic       rd_zero;
      logic [1:0] kind;
      logic       past;
   } cond_type;

   function automatic ctl_type ucode(input logic [4:0] upc);
      ctl_type w;
      w = '0;
      unique case (upc)
         5'd0:    w = '{1'b0, 1'b0, CAP_NONE, ACT_WRITE, 1'b1, J_NEXT};
         5'd1:    w = '{1'b0, 1'b0, CAP_NONE, ACT_RREG,  1'b1, J_NEXT};
         5'd2:    w = '{1'b0, 1'b0, CAP_NONE, ACT_NONE,  1'b0, J_NEXT};
         5'd3:    w = '{1'b0, 1'b0, CAP_NONE, ACT_RMEM,  1'b1, J_NEXT};
         5'd4:    w = '{1'b1, 1'b0, CAP_NONE, ACT_NONE,  1'b0, J_PCEND};
         5'd5:    w = '{1'b0, 1'b0, CAP_OPC,  ACT_NONE,  1'b0, J_ZERO};
         5'd6:    w = '{1'b0, 1'b1, CAP_NONE, ACT_NONE,  1'b0, J_OPC};
         5'd7:    w = '{1'b1, 1'b1, CAP_NONE, ACT_NONE,  1'b0, J_NEXT};
         5'd8:    w = '{1'b1, 1'b1, CAP_OP0,  ACT_NONE,  1'b0, J_NEXT};
         5'd9:    w = '{1'b0, 1'b0, CAP_OP1,  ACT_NONE,  1'b0, J_NEXT};
         5'd10:   w = '{1'b0, 1'b0, CAP_NONE, ACT_LS,    1'b1, J_NEXT};
         5'd11:   w = '{1'b1, 1'b1, CAP_NONE, ACT_NONE,  1'b0, J_NEXT};
         5'd12:   w = '{1'b1, 1'b1, CAP_OP0,  ACT_NONE,  1'b0, J_NEXT};
         5'd13:   w = '{1'b1, 1'b1, CAP_OP1,  ACT_NONE,  1'b0, J_NEXT};
         5'd14:   w = '{1'b0, 1'b0, CAP_OP2,  ACT_ACC,   1'b0, J_NEXT};
         5'd15:   w = '{1'b0, 1'b0, CAP_NONE, ACT_ADD,   1'b1, J_NEXT};
         5'd16:   w = '{1'b0, 1'b0, CAP_NONE, ACT_UNK,   1'b1, J_NEXT};
         5'd17:   w = '{1'b0, 1'b0, CAP_NONE, ACT_PAST,  1'b1, J_NEXT};
         5'd18:   w = '{1'b0, 1'b0, CAP_NONE, ACT_HALT,  1'b1, J_NEXT};
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/tfoc_useq.sv =====
// Microcode sequencer: step counter, control ROM and jump logic.
`default_nettype none

module tfoc_useq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [1:0]        cmd,
   input  wire logic              hold,
   input  wire tfoc_pkg::cond_type cond,
   output tfoc_pkg::ctl_type      ctl,
   output logic                   busy
);
   import tfoc_pkg::*;

   logic       busy_ff, busy_in;
   logic [4:0] upc_ff, upc_in;
   logic [4:0] upc_nx;
   logic [4:0] entry;

   assign ctl  = ucode(upc_ff);
   assign busy = busy_ff;

   always_comb begin
      unique case (cmd)
         CMD_WRITE: entry = ROW_WRITE;
         CMD_STEP:  entry = ROW_STEP;
         CMD_RREG:  entry = ROW_RREG;
         default:   entry = ROW_RMEM;
      endcase
   end

   always_comb begin
      unique case (ctl.jmp)
         J_PCEND: upc_nx = cond.pc_end ? ROW_HALT : upc_ff + 5'd1;
         J_ZERO:  upc_nx = cond.rd_zero ? ROW_HALT : upc_ff + 5'd1;
         J_OPC: begin
            priority if (cond.kind == KIND_UNK) upc_nx = ROW_UNK;
            else if (cond.past)                 upc_nx = ROW_PAST;
            else if (cond.kind == KIND_ADD)     upc_nx = ROW_ADD;
            else                                upc_nx = ROW_LS;
         end
         default: upc_nx = upc_ff + 5'd1;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      upc_in  = upc_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            upc_in  = entry;
         end
      end else if (!hold) begin
         if (ctl.fin) begin
            busy_in = 1'b0;
         end else begin
            upc_in = upc_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         upc_ff  <= ROW_WRITE;
      end else begin
         busy_ff <= busy_in;
         upc_ff  <= upc_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tiny_four_opcode_cpu_top.sv =====
// Top level of the tiny four-opcode processor: datapath, storage and result register.
//
//  channel | dir | tdata (low bit first)                            | tuser
//  req_    | in  | address[3:0], data[35:4], zero pad to 40         | cmd
//  rsp_    | out | read_data, opcode_seen, dest_index, written_value,| status, dest_kind
//          |     | pc_after, zero pad to 112                        |
//
//  One item at a time. Write and register read take the shortest time, then memory read;
//  a step is shortest when halted, longer for an unknown opcode, longer still for LOAD or
//  STORE and longest for ADD; the single memory port fetching operand words one per cycle
//  sets the step length. Reset clears memory valid bits, registers and the counter
//  at once. A stalled result holds the sequencer at its final step.
`default_nettype none

module tiny_four_opcode_cpu_top #(
   parameter int MEM_WORDS = 16,
   parameter int NUM_REGS  = 4
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // address, data
   input  wire logic [tfoc_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // cmd
   input  wire logic [1:0]                         req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // read_data, opcode_seen, dest_index, written_value, pc_after
   output logic [tfoc_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   // status, dest_kind
   output logic [3:0]                              rsp_tuser
);
   import tfoc_pkg::*;

   localparam int AW  = $clog2(MEM_WORDS);
   localparam int RW  = $clog2(NUM_REGS);
   localparam int PCW = $clog2(MEM_WORDS + 1);
   localparam int PCX = PCW + 1;

   ctl_type  ctl;
   cond_type cond;
   logic     busy, hold, adv, accept;

   logic [3:0]  addr_ff;
   logic [31:0] data_ff;
   logic [PCW-1:0] pc_ff, pc_in;
   logic [31:0] opc_ff, op0_ff, op1_ff, op2_ff, acc_ff;

   logic [31:0]          mem_ff [MEM_WORDS];
   logic [MEM_WORDS-1:0] vld_ff;
   logic [31:0]          mem_rd_ff;
   logic [AW-1:0]        mem_ra;

   logic [31:0] regs_ff [NUM_REGS];
   logic [RW-1:0] rf_ra;
   logic [31:0] rf_rd;

   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [31:0]   mem_wd;
   logic          rf_we;
   logic [RW-1:0] rf_wa;
   logic [31:0]   rf_wd;

   logic [1:0]  st_in, dk_in;
   logic [31:0] rdata_in, opseen_in, wval_in, sum;
   logic [3:0]  didx_in;

   logic        rsp_valid_ff;
   logic [1:0]  st_ff, dk_ff;
   logic [31:0] rdata_ff, opseen_ff, wval_ff;
   logic [3:0]  didx_ff;
   logic [4:0]  pca_ff;

   logic addr_mem_ok, addr_reg_ok, ls_ok, add_ok;
   logic [PCX-1:0] fetch_end;

   assign req_tready = !busy;
   assign accept     = req_tvalid && req_tready;
   assign hold       = ctl.fin && rsp_valid_ff && !rsp_tready;
   assign adv        = busy && !hold;

   tfoc_useq u_useq (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .cmd   (req_tuser),
      .hold  (hold),
      .cond  (cond),
      .ctl   (ctl),
      .busy  (busy)
   );

   always_comb begin
      cond.pc_end  = pc_ff >= PCW'(MEM_WORDS);
      cond.rd_zero = mem_rd_ff == 32'd0;
      if (opc_ff == OPC_LOAD || opc_ff == OPC_STORE) begin
         cond.kind = KIND_LS;
      end else if (opc_ff == OPC_ADD) begin
         cond.kind = KIND_ADD;
      end else begin
         cond.kind = KIND_UNK;
      end
      fetch_end = PCX'(pc_ff) + ((opc_ff == OPC_ADD) ? PCX'(4) : PCX'(3));
      cond.past = fetch_end > PCX'(MEM_WORDS);
   end

   assign mem_ra = ctl.rd_pc ? AW'(pc_ff) : AW'(addr_ff);

   always_comb begin
      unique case (ctl.act)
         ACT_RREG: rf_ra = RW'(addr_ff);
         ACT_ADD:  rf_ra = RW'(op1_ff);
         default:  rf_ra = RW'(op0_ff);
      endcase
   end
   assign rf_rd = regs_ff[rf_ra];

   assign addr_mem_ok = 32'(addr_ff) < 32'(MEM_WORDS);
   assign addr_reg_ok = 32'(addr_ff) < 32'(NUM_REGS);
   assign ls_ok  = op0_ff < 32'(NUM_REGS) && (opc_ff == OPC_LOAD || op1_ff < 32'(MEM_WORDS));
   assign add_ok = op0_ff < 32'(NUM_REGS) && op1_ff < 32'(NUM_REGS) && op2_ff < 32'(NUM_REGS);
   assign sum    = acc_ff + rf_rd;

   always_comb begin
      pc_in     = ctl.pc_inc ? PCW'(pc_ff + 1'b1) : pc_ff;
      mem_we    = 1'b0;
      mem_wa    = AW'(addr_ff);
      mem_wd    = data_ff;
      rf_we     = 1'b0;
      rf_wa     = RW'(op0_ff);
      rf_wd     = op1_ff;
      st_in     = ST_DONE;
      rdata_in  = '0;
      opseen_in = '0;
      dk_in     = DK_NONE;
      didx_in   = '0;
      wval_in   = '0;
      unique case (ctl.act)
         ACT_WRITE: begin
            if (addr_mem_ok) mem_we = 1'b1;
            else             st_in  = ST_FAULT;
         end
         ACT_RREG: begin
            if (addr_reg_ok) rdata_in = rf_rd;
            else             st_in    = ST_FAULT;
         end
         ACT_RMEM: begin
            if (addr_mem_ok) rdata_in = mem_rd_ff;
            else             st_in    = ST_FAULT;
         end
         ACT_UNK: begin
            st_in     = ST_UNKNOWN;
            opseen_in = opc_ff;
         end
         ACT_PAST: begin
            st_in     = ST_FAULT;
            opseen_in = opc_ff;
            pc_in     = PCW'(MEM_WORDS);
         end
         ACT_HALT: begin
            st_in = ST_HALT;
         end
         ACT_LS: begin
            opseen_in = opc_ff;
            if (!ls_ok) begin
               st_in = ST_FAULT;
            end else if (opc_ff == OPC_LOAD) begin
               rf_we   = 1'b1;
               dk_in   = DK_REG;
               didx_in = 4'(op0_ff);
               wval_in = op1_ff;
            end else begin
               mem_we  = 1'b1;
               mem_wa  = AW'(op1_ff);
               mem_wd  = rf_rd;
               dk_in   = DK_MEM;
               didx_in = 4'(op1_ff);
               wval_in = rf_rd;
            end
         end
         ACT_ADD: begin
            opseen_in = opc_ff;
            if (add_ok) begin
               rf_we   = 1'b1;
               rf_wa   = RW'(op2_ff);
               rf_wd   = sum;
               dk_in   = DK_REG;
               didx_in = 4'(op2_ff);
               wval_in = sum;
            end else begin
               st_in = ST_FAULT;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff <= req_tdata[3:0];
         data_ff <= req_tdata[35:4];
      end
      if (adv) begin
         mem_rd_ff <= vld_ff[mem_ra] ? mem_ff[mem_ra] : 32'd0;
         unique case (ctl.cap)
            CAP_OPC: opc_ff <= mem_rd_ff;
            CAP_OP0: op0_ff <= mem_rd_ff;
            CAP_OP1: op1_ff <= mem_rd_ff;
            CAP_OP2: op2_ff <= mem_rd_ff;
            default: begin
            end
         endcase
         if (ctl.act == ACT_ACC) acc_ff <= rf_rd;
         if (mem_we) mem_ff[mem_wa] <= mem_wd;
      end
      if (adv && ctl.fin) begin
         st_ff     <= st_in;
         rdata_ff  <= rdata_in;
         opseen_ff <= opseen_in;
         dk_ff     <= dk_in;
         didx_ff   <= didx_in;
         wval_ff   <= wval_in;
         pca_ff    <= 5'(pc_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) regs_ff[i] <= '0;
      end else begin
         if (adv) begin
            pc_ff <= pc_in;
            if (mem_we) vld_ff[mem_wa] <= 1'b1;
            if (rf_we)  regs_ff[rf_wa] <= rf_wd;
         end
         if (adv && ctl.fin) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, pca_ff, wval_ff, didx_ff, opseen_ff, rdata_ff};
   assign rsp_tuser  = {dk_ff, st_ff};

endmodule

`default_nettype wire
